// ===== src/spmf_pkg.sv =====
package spmf_pkg;

	typedef enum logic [1:0] {
		MODE_ENQ   = 2'd0,
		MODE_DEQ   = 2'd1,
		MODE_PEEK  = 2'd2,
		MODE_CLEAR = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_LIMIT   = 3'd1,
		ST_EMPTY   = 3'd2,
		ST_FULL    = 3'd3,
		ST_BAD_PRI = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_READ = 2'd1,
		PH_OUT  = 2'd2
	} phase_t;

	localparam logic CFG_MSG_LIMIT  = 1'b0;
	localparam logic CFG_BYTE_LIMIT = 1'b1;

	// level count and per-level depth, tied to the field widths of the ports
	localparam int LEVELS      = 16;
	localparam int LEVEL_DEPTH = 64;

	localparam int ENTRY_W = 160;

endpackage

// ===== src/spmf_ram.sv =====
module spmf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/strict_priority_multi_fifo.sv =====
// an accepted item passes the read phase, in which the registered ram read data is valid and
// the result register is loaded, then the output phase, where the result is offered
// one item in flight at a time: the single-item sequencer (idle, read, output) takes no new
// item before the last result is taken; a stalled output holds off the input
// reset: arst_n clears pointers, fill counts, totals, limits and the sequencer at once;
// entry storage is not cleared and only ever used after being written
module strict_priority_multi_fifo (
	input  logic         clk,
	input  logic         arst_n,
	// tdata: mode[1:0] priority_req[5:2] payload_handle[37:6] topic_handle[69:38]
	// payload_len[85:70] topic_len[101:86] enqueue_time[165:102]
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [167:0] s_tdata,
	// tdata: status[2:0] out_priority[6:3] out_payload[38:7] out_topic[70:39]
	// out_payload_len[86:71] out_topic_len[102:87] out_time[166:103]
	// message_total[177:167] byte_total[209:178] top_priority[213:210] level_count[220:214]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [223:0] m_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [31:0]  cfg_data
);

	localparam int LEVELS      = spmf_pkg::LEVELS;
	localparam int LEVEL_DEPTH = spmf_pkg::LEVEL_DEPTH;
	localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int SW = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
	localparam int FW = $clog2(LEVEL_DEPTH + 1);
	localparam int DEPTH = LEVELS * LEVEL_DEPTH;
	localparam int AW = $clog2(DEPTH);

	// input fields
	logic [1:0]  in_mode;
	logic [3:0]  in_pri;
	logic [31:0] in_ph, in_th;
	logic [15:0] in_pl, in_tl;
	logic [63:0] in_time;
	assign in_mode = s_tdata[1:0];
	assign in_pri  = s_tdata[5:2];
	assign in_ph   = s_tdata[37:6];
	assign in_th   = s_tdata[69:38];
	assign in_pl   = s_tdata[85:70];
	assign in_tl   = s_tdata[101:86];
	assign in_time = s_tdata[165:102];

	spmf_pkg::phase_t ph_q, ph_d;
	logic [15:0] msg_limit_q;
	logic [31:0] byte_limit_q;
	logic [SW-1:0] head_q [LEVELS];
	logic [SW-1:0] tail_q [LEVELS];
	logic [FW-1:0] fill_q [LEVELS];
	logic [10:0] msgs_q;
	logic [31:0] bytes_q;
	logic [3:0]  hi_q;

	// latched request
	logic [1:0]  mode_q;
	logic [3:0]  pri_q;
	logic [2:0]  stat_q;
	logic [LW-1:0] lvl_q;
	logic [223:0] out_q;
	logic [223:0] out_d;

	logic acc;
	assign s_tready = (ph_q == spmf_pkg::PH_IDLE);
	assign acc = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid = (ph_q == spmf_pkg::PH_OUT);
	assign m_tdata = out_q;

	// highest nonempty level, priority encoder over the fill counts
	logic [LW-1:0] top_lv;
	logic          any_ne;
	always_comb begin
		top_lv = '0;
		any_ne = 1'b0;
		for (int i = 0; i < LEVELS; i++) begin
			if (fill_q[i] != '0) begin
				top_lv = LW'(i);
				any_ne = 1'b1;
			end
		end
	end

	// enqueue check on the accepted item
	logic        pri_ok;
	logic [LW-1:0] pri_lv;
	logic [32:0] nb;
	logic [2:0]  enq_st;
	assign pri_ok = ({28'd0, in_pri} < LEVELS);
	assign pri_lv = LW'(in_pri);
	assign nb = {1'b0, bytes_q} + 33'(in_pl) + 33'(in_tl);
	always_comb begin
		if (!pri_ok) enq_st = spmf_pkg::ST_BAD_PRI;
		else if (msg_limit_q != '0 && {5'd0, msgs_q} >= msg_limit_q) enq_st = spmf_pkg::ST_LIMIT;
		else if (byte_limit_q != '0 && nb > {1'b0, byte_limit_q}) enq_st = spmf_pkg::ST_LIMIT;
		else if (fill_q[pri_lv] == FW'(LEVEL_DEPTH)) enq_st = spmf_pkg::ST_FULL;
		else enq_st = spmf_pkg::ST_OK;
	end

	// entry ram
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [spmf_pkg::ENTRY_W-1:0] wdata, rdata;
	assign we = acc && in_mode == spmf_pkg::MODE_ENQ && enq_st == spmf_pkg::ST_OK;
	assign waddr = AW'(pri_lv) * AW'(LEVEL_DEPTH) + AW'(tail_q[pri_lv]);
	assign wdata = {in_time, in_pl, in_tl, in_ph, in_th};
	assign raddr = AW'(top_lv) * AW'(LEVEL_DEPTH) + AW'(head_q[top_lv]);

	spmf_ram #(.WIDTH(spmf_pkg::ENTRY_W), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	// sequencer
	always_comb begin
		case (ph_q)
			spmf_pkg::PH_IDLE: ph_d = acc ? spmf_pkg::PH_READ : spmf_pkg::PH_IDLE;
			spmf_pkg::PH_READ: ph_d = spmf_pkg::PH_OUT;
			spmf_pkg::PH_OUT:  ph_d = m_tready ? spmf_pkg::PH_IDLE : spmf_pkg::PH_OUT;
			default:           ph_d = spmf_pkg::PH_IDLE;
		endcase
	end

	// read-side values in the read phase
	logic [15:0] r_pl, r_tl;
	logic [16:0] mb;
	logic        take;
	logic        deq_ok;
	assign r_tl = rdata[79:64];
	assign r_pl = rdata[95:80];
	assign mb = 17'(r_pl) + 17'(r_tl);
	assign deq_ok = (stat_q == spmf_pkg::ST_OK);
	assign take = (mode_q == spmf_pkg::MODE_DEQ) && deq_ok;

	// highest nonempty level after this dequeue, excluding level lvl_q when it empties
	logic [3:0] nt;
	always_comb begin
		nt = '0;
		for (int i = 0; i < LEVELS; i++) begin
			if (fill_q[i] != '0 && !(LW'(i) == lvl_q && fill_q[i] == FW'(1))) nt = 4'(i);
		end
	end

	logic [10:0] msgs_n;
	logic [31:0] bytes_n;
	logic [3:0]  hi_n;
	logic [6:0]  lc_n;
	always_comb begin
		msgs_n = msgs_q;
		bytes_n = bytes_q;
		hi_n = hi_q;
		if (take) begin
			msgs_n = msgs_q - 11'd1;
			bytes_n = ({15'd0, mb} < {1'b0, bytes_q}) ? bytes_q - 32'(mb) : '0;
			if (fill_q[lvl_q] == FW'(1) && 4'(lvl_q) == hi_q) hi_n = nt;
		end
		lc_n = '0;
		if ({28'd0, pri_q} < LEVELS) begin
			lc_n = 7'(fill_q[LW'(pri_q)]);
			if (take && LW'(pri_q) == lvl_q) lc_n = lc_n - 7'd1;
		end
	end

	// result word; message fields stay zero unless a dequeue or peek found an entry
	always_comb begin
		out_d = '0;
		out_d[2:0] = stat_q;
		if ((mode_q == spmf_pkg::MODE_DEQ || mode_q == spmf_pkg::MODE_PEEK) && deq_ok) begin
			out_d[6:3]     = 4'(lvl_q);
			out_d[38:7]    = rdata[63:32];
			out_d[70:39]   = rdata[31:0];
			out_d[86:71]   = r_pl;
			out_d[102:87]  = r_tl;
			out_d[166:103] = rdata[159:96];
		end
		out_d[177:167] = msgs_n;
		out_d[209:178] = bytes_n;
		out_d[213:210] = hi_n;
		out_d[220:214] = lc_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= spmf_pkg::PH_IDLE;
			msg_limit_q <= '0;
			byte_limit_q <= '0;
			msgs_q <= '0;
			bytes_q <= '0;
			hi_q <= '0;
			for (int i = 0; i < LEVELS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				fill_q[i] <= '0;
			end
		end else begin
			ph_q <= ph_d;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == spmf_pkg::CFG_MSG_LIMIT) msg_limit_q <= cfg_data[15:0];
				else byte_limit_q <= cfg_data;
			end
			if (acc && in_mode == spmf_pkg::MODE_CLEAR) begin
				msgs_q <= '0;
				bytes_q <= '0;
				hi_q <= '0;
				for (int i = 0; i < LEVELS; i++) begin
					head_q[i] <= '0;
					tail_q[i] <= '0;
					fill_q[i] <= '0;
				end
			end
			if (we) begin
				tail_q[pri_lv] <= (tail_q[pri_lv] == SW'(LEVEL_DEPTH - 1)) ? '0 : tail_q[pri_lv] + SW'(1);
				fill_q[pri_lv] <= fill_q[pri_lv] + FW'(1);
				msgs_q <= msgs_q + 11'd1;
				bytes_q <= nb[32] ? 32'hFFFF_FFFF : nb[31:0];
				if (in_pri > hi_q) hi_q <= in_pri;
			end
			if (ph_q == spmf_pkg::PH_READ && take) begin
				head_q[lvl_q] <= (head_q[lvl_q] == SW'(LEVEL_DEPTH - 1)) ? '0 : head_q[lvl_q] + SW'(1);
				fill_q[lvl_q] <= fill_q[lvl_q] - FW'(1);
				msgs_q <= msgs_n;
				bytes_q <= bytes_n;
				hi_q <= hi_n;
			end
		end
	end

	// request capture and result register
	always_ff @(posedge clk) begin
		if (acc) begin
			mode_q <= in_mode;
			pri_q <= in_pri;
			lvl_q <= top_lv;
			if (in_mode == spmf_pkg::MODE_ENQ) stat_q <= enq_st;
			else if (in_mode == spmf_pkg::MODE_CLEAR) stat_q <= spmf_pkg::ST_OK;
			else stat_q <= (msgs_q == '0 || !any_ne) ? spmf_pkg::ST_EMPTY : spmf_pkg::ST_OK;
		end
		if (ph_q == spmf_pkg::PH_READ) begin
			out_q <= out_d;
		end
	end

	// one item in flight at a time
	assert property (@(posedge clk) disable iff (!arst_n) m_tvalid |-> !s_tready)
		else $error("input taken while a result is pending");
	// the message total never exceeds the storage
	assert property (@(posedge clk) disable iff (!arst_n) msgs_q <= 11'(DEPTH))
		else $error("message total beyond storage");
	// a write never lands while an output is pending
	assert property (@(posedge clk) disable iff (!arst_n) we |-> ph_q == spmf_pkg::PH_IDLE)
		else $error("ram write outside idle");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

// queue model for the strict-priority fifo: tracks per-level contents and totals
class spmf_scoreboard;

	typedef struct packed {
		logic [31:0] pay_h;
		logic [31:0] top_h;
		logic [15:0] pay_l;
		logic [15:0] top_l;
		logic [63:0] stamp;
	} desc_t;

	desc_t       lvl_q[16][$];
	int unsigned msg_count;
	logic [31:0] byte_count;
	logic [3:0]  top_lvl;
	logic [15:0] msg_limit;
	logic [31:0] byte_cap;
	logic [223:0] pending[$];
	int          errors;

	function new();
		msg_count = 0;
		byte_count = '0;
		top_lvl = '0;
		msg_limit = '0;
		byte_cap = '0;
		errors = 0;
	endfunction

	function void set_reg(logic idx, logic [31:0] val);
		if (idx == spmf_pkg::CFG_MSG_LIMIT) msg_limit = val[15:0];
		else byte_cap = val;
	endfunction

	function int highest_nonempty();
		for (int l = 15; l >= 0; l--)
			if (lvl_q[l].size() != 0) return l;
		return -1;
	endfunction

	// predicts the result of one accepted transfer and queues it
	function void note_item(logic [167:0] d);
		spmf_pkg::mode_t   md;
		logic [3:0]        pr;
		desc_t             e;
		desc_t             f;
		spmf_pkg::status_t st;
		logic [32:0]       nb;
		int                lv;
		int                nt;
		logic [223:0]      r;
		md = spmf_pkg::mode_t'(d[1:0]);
		pr = d[5:2];
		e = {d[37:6], d[69:38], d[85:70], d[101:86], d[165:102]};
		f = '0;
		st = spmf_pkg::ST_OK;
		lv = 0;
		case (md)
			spmf_pkg::MODE_ENQ: begin
				nb = {1'b0, byte_count} + 33'(e.pay_l) + 33'(e.top_l);
				if (msg_limit != '0 && msg_count >= 32'(msg_limit)) st = spmf_pkg::ST_LIMIT;
				else if (byte_cap != '0 && nb > {1'b0, byte_cap}) st = spmf_pkg::ST_LIMIT;
				else if (lvl_q[pr].size() >= 64) st = spmf_pkg::ST_FULL;
				else begin
					lvl_q[pr].push_back(e);
					msg_count++;
					byte_count = nb[32] ? 32'hFFFF_FFFF : nb[31:0];
					if (pr > top_lvl) top_lvl = pr;
				end
			end
			spmf_pkg::MODE_DEQ, spmf_pkg::MODE_PEEK: begin
				lv = highest_nonempty();
				if (msg_count == 0 || lv < 0) st = spmf_pkg::ST_EMPTY;
				else begin
					f = lvl_q[lv][0];
					if (md == spmf_pkg::MODE_DEQ) begin
						void'(lvl_q[lv].pop_front());
						msg_count--;
						nb = 33'(f.pay_l) + 33'(f.top_l);
						byte_count = (byte_count > nb[31:0]) ? byte_count - nb[31:0] : '0;
						if (lvl_q[lv].size() == 0 && lv == int'(top_lvl)) begin
							nt = highest_nonempty();
							top_lvl = (nt < 0) ? 4'd0 : 4'(nt);
						end
					end
				end
			end
			default: begin
				for (int l = 0; l < 16; l++) lvl_q[l].delete();
				msg_count = 0;
				byte_count = '0;
				top_lvl = '0;
			end
		endcase
		if (st != spmf_pkg::ST_OK || md == spmf_pkg::MODE_ENQ || md == spmf_pkg::MODE_CLEAR) begin
			f = '0;
			lv = 0;
		end
		r = '0;
		r[2:0] = st;
		r[6:3] = lv[3:0];
		r[38:7] = f.pay_h;
		r[70:39] = f.top_h;
		r[86:71] = f.pay_l;
		r[102:87] = f.top_l;
		r[166:103] = f.stamp;
		r[177:167] = msg_count[10:0];
		r[209:178] = byte_count;
		r[213:210] = top_lvl;
		r[220:214] = 7'(lvl_q[pr].size());
		pending.push_back(r);
	endfunction

	function void check_result(logic [223:0] got);
		logic [223:0] w;
		if (pending.size() == 0) begin
			errors++;
			if (errors <= 10) $display("unexpected result %h", got);
			return;
		end
		w = pending.pop_front();
		if (got !== w) begin
			errors++;
			if (errors <= 10) begin
				$display("mismatch: status exp %0d got %0d, pri exp %0d got %0d",
					w[2:0], got[2:0], w[6:3], got[6:3]);
				$display("  handles exp %h/%h got %h/%h, lens exp %h/%h got %h/%h",
					w[38:7], w[70:39], got[38:7], got[70:39],
					w[86:71], w[102:87], got[86:71], got[102:87]);
				$display("  time exp %h got %h, msgs exp %0d got %0d, bytes exp %h got %h",
					w[166:103], got[166:103], w[177:167], got[177:167],
					w[209:178], got[209:178]);
				$display("  top exp %0d got %0d, level count exp %0d got %0d",
					w[213:210], got[213:210], w[220:214], got[220:214]);
			end
		end
	endfunction
endclass

module tb;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [167:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [223:0] m_tdata;
	logic         cfg_valid;
	logic         cfg_ready;
	logic         cfg_index;
	logic [31:0]  cfg_data;

	// idle percentages for sender and receiver, changed per phase
	int           send_idle;
	int           recv_idle;
	// long receiver hold-off, started by the stimulus and counted by its own process
	logic         hold_go;
	logic         hold_on;
	int           item_count;

	spmf_scoreboard sb;

	strict_priority_multi_fifo u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// hold-off counter: once started, keeps the receiver off until its count runs out
	initial begin
		hold_on = 1'b0;
		@(posedge hold_go);
		hold_on = 1'b1;
		repeat (300) @(negedge clk);
		hold_on = 1'b0;
	end

	// receiver: random stalls, held off entirely during the hold-off
	always @(negedge clk) begin
		if (hold_on) m_tready <= 1'b0;
		else m_tready <= ($urandom_range(99) >= recv_idle);
	end

	// results checked at the rising edge of each output transfer
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
	end

	// one input transfer; the item is noted once accepted
	task automatic send_item(spmf_pkg::mode_t md, logic [3:0] pr, logic [31:0] ph,
		logic [31:0] th, logic [15:0] pl, logic [15:0] tl, logic [63:0] ts);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {2'b00, ts, tl, pl, th, ph, pr, md};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_item(s_tdata);
		item_count++;
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic write_reg(logic idx, logic [31:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// waits until every expected result has come, then lets the pipeline settle
	task automatic drain();
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic rand_item(int enq_bias, logic [15:0] len_max);
		int              r;
		spmf_pkg::mode_t md;
		r = $urandom_range(99);
		if (r < enq_bias) md = spmf_pkg::MODE_ENQ;
		else if (r < 92) md = spmf_pkg::MODE_DEQ;
		else if (r < 99) md = spmf_pkg::MODE_PEEK;
		else md = spmf_pkg::MODE_CLEAR;
		send_item(md, 4'($urandom_range(15)), $urandom, $urandom,
			16'($urandom_range(len_max)), 16'($urandom_range(len_max)),
			{$urandom, $urandom});
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		send_idle = 0;
		recv_idle = 0;
		hold_go = 1'b0;
		item_count = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty queue, field extremes, every mode, saturation
		send_item(spmf_pkg::MODE_DEQ, 4'd0, '0, '0, '0, '0, '0);
		send_item(spmf_pkg::MODE_PEEK, 4'd15, '0, '0, '0, '0, '0);
		send_item(spmf_pkg::MODE_ENQ, 4'd0, 32'h0, 32'h0, 16'h0, 16'h0, 64'h0);
		send_item(spmf_pkg::MODE_ENQ, 4'd15, '1, '1, '1, '1, '1);
		send_item(spmf_pkg::MODE_ENQ, 4'd7, 32'hA5A5_5A5A, 32'h5A5A_A5A5, 16'h8001, 16'h7FFE,
			64'h8000_0000_0000_0001);
		send_item(spmf_pkg::MODE_PEEK, 4'd7, '0, '0, '0, '0, '0);
		send_item(spmf_pkg::MODE_DEQ, 4'd15, '0, '0, '0, '0, '0);
		send_item(spmf_pkg::MODE_DEQ, 4'd7, '0, '0, '0, '0, '0);
		send_item(spmf_pkg::MODE_CLEAR, 4'd0, '0, '0, '0, '0, '0);
		send_item(spmf_pkg::MODE_PEEK, 4'd0, '0, '0, '0, '0, '0);
		// fill one level to capacity; the extra enqueue is refused as full
		for (int i = 0; i < 65; i++)
			send_item(spmf_pkg::MODE_ENQ, 4'd3, 32'(i), ~32'(i), '1, '1, 64'(i));
		send_item(spmf_pkg::MODE_DEQ, 4'd3, '0, '0, '0, '0, '0);
		drain();

		// message limit at one, then byte limit just hit
		write_reg(spmf_pkg::CFG_MSG_LIMIT, 32'd1);
		write_reg(spmf_pkg::CFG_BYTE_LIMIT, 32'd10);
		send_item(spmf_pkg::MODE_CLEAR, 4'd0, '0, '0, '0, '0, '0);
		send_item(spmf_pkg::MODE_ENQ, 4'd2, 32'd1, 32'd2, 16'd6, 16'd5, 64'd1);
		send_item(spmf_pkg::MODE_ENQ, 4'd2, 32'd1, 32'd2, 16'd6, 16'd4, 64'd1);
		send_item(spmf_pkg::MODE_ENQ, 4'd2, 32'd1, 32'd2, 16'd0, 16'd0, 64'd1);
		drain();
		write_reg(spmf_pkg::CFG_MSG_LIMIT, 32'hFFFF);
		write_reg(spmf_pkg::CFG_BYTE_LIMIT, 32'hFFFF_FFFF);
		send_item(spmf_pkg::MODE_CLEAR, 4'd0, '0, '0, '0, '0, '0);

		// pressure: receiver holds off while the sender keeps offering items
		hold_go = 1'b1;
		for (int i = 0; i < 40; i++) rand_item(60, 16'hFFFF);
		drain();

		// random phases with different idle patterns and limit settings
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle = 0;  recv_idle = 0;  end
				1: begin send_idle = 58; recv_idle = 0;  end
				2: begin send_idle = 0;  recv_idle = 58; end
				default: begin send_idle = 36; recv_idle = 36; end
			endcase
			case (ph)
				0: begin
					write_reg(spmf_pkg::CFG_MSG_LIMIT, 32'd0);
					write_reg(spmf_pkg::CFG_BYTE_LIMIT, 32'd0);
				end
				2: begin write_reg(spmf_pkg::CFG_MSG_LIMIT, 32'd20); end
				3: begin write_reg(spmf_pkg::CFG_BYTE_LIMIT, 32'd300000); end
				5: begin
					write_reg(spmf_pkg::CFG_MSG_LIMIT, 32'd0);
					write_reg(spmf_pkg::CFG_BYTE_LIMIT, 32'd500);
				end
				6: begin write_reg(spmf_pkg::CFG_BYTE_LIMIT, 32'd0); end
				default: ;
			endcase
			for (int i = 0; i < 130; i++)
				rand_item((ph % 2) ? 70 : 55, (ph == 5) ? 16'd60 : 16'hFFFF);
			drain();
		end

		send_idle = 0;
		recv_idle = 0;
		drain();
		if (sb.errors == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end

	initial begin
		#5ms;
		$display("Simulation FAILED");
		$finish;
	end
endmodule
